// ===== rtl/nsc_pkg.sv =====
// Shared types and constants for the nested comment stripper.
package nsc_pkg;

	localparam int DEPTH_BITS_DEF = 8;
	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
	localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_BLOCK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_SLASH = 2'd1,
		HOLD_STAR  = 2'd2
	} held_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_OK   = 2'd1,
		KIND_OPEN = 2'd2,
		KIND_OVF  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] out_char;
		kind_t      kind;
		logic       last_of_run;
	} res_t;

endpackage

// ===== rtl/nsc_scan.sv =====
// Scanner step: next state and up to two result beats for one source byte.
module nsc_scan #(
	parameter int DEPTH_BITS = nsc_pkg::DEPTH_BITS_DEF
) (
	input  nsc_pkg::mode_t         mode,
	input  nsc_pkg::held_t         held,
	input  logic [DEPTH_BITS-1:0]  depth,
	input  logic                   ovf,
	input  logic [7:0]             char_byte,
	input  logic                   end_of_source,
	output nsc_pkg::mode_t         mode_nxt,
	output nsc_pkg::held_t         held_nxt,
	output logic [DEPTH_BITS-1:0]  depth_nxt,
	output logic                   ovf_nxt,
	output logic [1:0]             res_cnt,
	output nsc_pkg::res_t          res0,
	output nsc_pkg::res_t          res1
);
	import nsc_pkg::*;

	kind_t end_kind;

	always_comb begin
		if (ovf) begin
			end_kind = KIND_OVF;
		end else if (mode == MODE_BLOCK) begin
			end_kind = KIND_OPEN;
		end else begin
			end_kind = KIND_OK;
		end
	end

	always_comb begin
		mode_nxt  = mode;
		held_nxt  = held;
		depth_nxt = depth;
		ovf_nxt   = ovf;
		res_cnt   = 2'd0;
		res0      = '{out_char: 8'h00, kind: KIND_CHAR, last_of_run: 1'b1};
		res1      = '{out_char: 8'h00, kind: KIND_CHAR, last_of_run: 1'b1};
		if (end_of_source) begin
			// flush a held slash, report, then drop back to reset state
			if (mode != MODE_LINE && mode != MODE_BLOCK && held == HOLD_SLASH) begin
				res0    = '{out_char: CH_SLASH, kind: KIND_CHAR, last_of_run: 1'b0};
				res1    = '{out_char: 8'h00, kind: end_kind, last_of_run: 1'b1};
				res_cnt = 2'd2;
			end else begin
				res0    = '{out_char: 8'h00, kind: end_kind, last_of_run: 1'b1};
				res_cnt = 2'd1;
			end
			mode_nxt  = MODE_TEXT;
			held_nxt  = HOLD_NONE;
			depth_nxt = '0;
			ovf_nxt   = 1'b0;
		end else begin
			unique case (mode)
				MODE_LINE: begin
					if (char_byte == CH_NL) begin
						res0     = '{out_char: char_byte, kind: KIND_CHAR, last_of_run: 1'b1};
						res_cnt  = 2'd1;
						mode_nxt = MODE_TEXT;
					end
					held_nxt = HOLD_NONE;
				end
				MODE_BLOCK: begin
					if (char_byte == CH_NL) begin
						res0     = '{out_char: char_byte, kind: KIND_CHAR, last_of_run: 1'b1};
						res_cnt  = 2'd1;
						held_nxt = HOLD_NONE;
					end else if (held == HOLD_SLASH && char_byte == CH_STAR) begin
						held_nxt = HOLD_NONE;
						// saturate at full scale and flag it
						if (depth == '1) begin
							ovf_nxt = 1'b1;
						end else begin
							depth_nxt = depth + DEPTH_BITS'(1);
						end
					end else if (held == HOLD_STAR && char_byte == CH_SLASH) begin
						held_nxt = HOLD_NONE;
						if (depth != '0) begin
							depth_nxt = depth - DEPTH_BITS'(1);
						end
						if (depth <= DEPTH_BITS'(1)) begin
							mode_nxt = MODE_TEXT;
						end
					end else if (char_byte == CH_SLASH) begin
						held_nxt = HOLD_SLASH;
					end else if (char_byte == CH_STAR) begin
						held_nxt = HOLD_STAR;
					end else begin
						held_nxt = HOLD_NONE;
					end
				end
				default: begin
					mode_nxt = MODE_TEXT;
					held_nxt = HOLD_NONE;
					if (held == HOLD_SLASH) begin
						if (char_byte == CH_SLASH) begin
							mode_nxt = MODE_LINE;
						end else if (char_byte == CH_STAR) begin
							mode_nxt  = MODE_BLOCK;
							depth_nxt = DEPTH_BITS'(1);
						end else begin
							res0    = '{out_char: CH_SLASH, kind: KIND_CHAR, last_of_run: 1'b0};
							res1    = '{out_char: char_byte, kind: KIND_CHAR, last_of_run: 1'b1};
							res_cnt = 2'd2;
						end
					end else if (char_byte == CH_SLASH) begin
						held_nxt = HOLD_SLASH;
					end else begin
						res0    = '{out_char: char_byte, kind: KIND_CHAR, last_of_run: 1'b1};
						res_cnt = 2'd1;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/nsc_res_fifo.sv =====
// Small result queue that takes up to two beats per cycle and gives one unless res_stall holds it.
module nsc_res_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_cnt,
	input  nsc_pkg::res_t                 push0,
	input  nsc_pkg::res_t                 push1,
	output logic [nsc_pkg::RES_CNT_W-1:0] fill,
	output logic                          res_valid,
	input  logic                          res_stall,
	output nsc_pkg::res_t                 res
);
	import nsc_pkg::*;

	res_t                 mem [RES_FIFO_DEPTH];
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = mem[rd_q];
	assign fill      = cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_q + RES_PTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(push_cnt);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/nested_comment_stripper_unit.sv =====
// Flow: an accepted byte is registered in the input stage and scanned from there; its
// result beats are written to the result queue, which offers the oldest at the result port.
// Throughput: one byte per cycle while the result queue has room; a two-beat item holds the
// result port for both beats, and the four-entry result queue sets when input stalls.
// Reset (arst_n low): normal text, nothing held, depth zero, queue empty.
module nested_comment_stripper_unit #(
	parameter int DEPTH_BITS = nsc_pkg::DEPTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_source,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_char,
	output logic [1:0] kind,
	output logic       last_of_run
);
	import nsc_pkg::*;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  eos_s1;
	logic                  proc;
	logic                  accept;

	mode_t                 mode_q;
	held_t                 held_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  ovf_q;

	mode_t                 mode_nxt;
	held_t                 held_nxt;
	logic [DEPTH_BITS-1:0] depth_nxt;
	logic                  ovf_nxt;
	logic [1:0]            res_cnt;
	res_t                  res0;
	res_t                  res1;
	res_t                  res_head;
	logic [RES_CNT_W-1:0]  fill;
	logic [1:0]            push_cnt;

	// scan only when the queue has room for a two-beat item
	assign proc      = valid_s1 && (fill <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
	assign src_stall = valid_s1 && !proc;
	assign accept    = src_valid && !src_stall;
	assign push_cnt  = proc ? res_cnt : 2'd0;

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
			eos_s1  <= end_of_source;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_TEXT;
			held_q   <= HOLD_NONE;
			depth_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				mode_q  <= mode_nxt;
				held_q  <= held_nxt;
				depth_q <= depth_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

	nsc_scan #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_scan (
		.mode         (mode_q),
		.held         (held_q),
		.depth        (depth_q),
		.ovf          (ovf_q),
		.char_byte    (char_s1),
		.end_of_source(eos_s1),
		.mode_nxt     (mode_nxt),
		.held_nxt     (held_nxt),
		.depth_nxt    (depth_nxt),
		.ovf_nxt      (ovf_nxt),
		.res_cnt      (res_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	nsc_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (res0),
		.push1    (res1),
		.fill     (fill),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res_head)
	);

	assign out_char    = res_head.out_char;
	assign kind        = res_head.kind;
	assign last_of_run = res_head.last_of_run;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= RES_CNT_W'(RES_FIFO_DEPTH))
		else $error("result queue overfilled");

	a_depth_block: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_BLOCK) |-> (depth_q != '0))
		else $error("block comment with zero depth");

	a_depth_text: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_BLOCK) |-> (depth_q == '0))
		else $error("nonzero depth outside block comment");

	a_star_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == HOLD_STAR) |-> (mode_q == MODE_BLOCK))
		else $error("star held outside block comment");
`endif

endmodule

// ===== sim/nested_comment_stripper_unit_tb.sv =====
// Self-checking testbench for the nested comment stripper: directed and random text streams, predicted beats.
`timescale 1ns / 1ps

module nested_comment_stripper_unit_tb;
	import nsc_pkg::*;

	localparam int          DEPTH_W     = DEPTH_BITS_DEF;
	localparam int          TOTAL_ITEMS = 1940;
	localparam int          TAIL_ITEMS  = 150;
	localparam int          MAX_REPORTS = 10;
	localparam int          SETTLE      = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0]  ch;
		logic        eos;
		int unsigned gap_after;
		bit          drain_first;
	} src_item_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       src_valid     = 1'b0;
	logic       src_stall;
	logic [7:0] char_byte     = 8'h00;
	logic       end_of_source = 1'b0;
	logic       res_valid;
	logic       res_stall     = 1'b0;
	logic [7:0] out_char;
	logic [1:0] kind;
	logic       last_of_run;

	// source bytes waiting to be driven, and stripped beats waiting to arrive
	src_item_t source_bytes[$];
	res_t      stripped_beats[$];
	src_item_t next_item;

	// scanner state as predicted
	mode_t              scan_state  = MODE_TEXT;
	held_t              held_mark   = HOLD_NONE;
	logic [DEPTH_W-1:0] nest_level  = '0;
	logic               nest_ovf    = 1'b0;

	int          errors       = 0;
	int          items_queued = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	int unsigned rx_phase     = 0;
	bit          rx_idle_on   = 1'b1;
	bit          tx_idle_on   = 1'b1;
	bit          drain_next   = 1'b0;
	int unsigned cycle_count  = 0;

	nested_comment_stripper_unit #(
		.DEPTH_BITS(DEPTH_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.char_byte    (char_byte),
		.end_of_source(end_of_source),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_char     (out_char),
		.kind         (kind),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// Advance the predicted scanner by one source item and queue the beats it yields.
	task automatic strip_char(input logic [7:0] c, input logic eos);
		res_t  beats[$];
		res_t  b;
		kind_t status;
		if (eos) begin
			if (scan_state != MODE_LINE && scan_state != MODE_BLOCK && held_mark == HOLD_SLASH)
				beats.push_back('{CH_SLASH, KIND_CHAR, 1'b0});
			if (nest_ovf)
				status = KIND_OVF;
			else if (scan_state == MODE_BLOCK)
				status = KIND_OPEN;
			else
				status = KIND_OK;
			beats.push_back('{8'h00, status, 1'b0});
			scan_state = MODE_TEXT;
			held_mark  = HOLD_NONE;
			nest_level = '0;
			nest_ovf   = 1'b0;
		end else if (scan_state == MODE_LINE) begin
			if (c == CH_NL) begin
				beats.push_back('{c, KIND_CHAR, 1'b0});
				scan_state = MODE_TEXT;
			end
			held_mark = HOLD_NONE;
		end else if (scan_state == MODE_BLOCK) begin
			if (c == CH_NL) begin
				beats.push_back('{c, KIND_CHAR, 1'b0});
				held_mark = HOLD_NONE;
			end else if (held_mark == HOLD_SLASH && c == CH_STAR) begin
				held_mark = HOLD_NONE;
				// saturate at full depth and remember it until end of source
				if (nest_level == '1)
					nest_ovf = 1'b1;
				else
					nest_level = nest_level + 1'b1;
			end else if (held_mark == HOLD_STAR && c == CH_SLASH) begin
				held_mark = HOLD_NONE;
				if (nest_level != '0)
					nest_level = nest_level - 1'b1;
				if (nest_level == '0)
					scan_state = MODE_TEXT;
			end else if (c == CH_SLASH) begin
				held_mark = HOLD_SLASH;
			end else if (c == CH_STAR) begin
				held_mark = HOLD_STAR;
			end else begin
				held_mark = HOLD_NONE;
			end
		end else begin
			scan_state = MODE_TEXT;
			if (held_mark == HOLD_SLASH) begin
				held_mark = HOLD_NONE;
				if (c == CH_SLASH) begin
					scan_state = MODE_LINE;
				end else if (c == CH_STAR) begin
					scan_state = MODE_BLOCK;
					nest_level = DEPTH_W'(1);
				end else begin
					beats.push_back('{CH_SLASH, KIND_CHAR, 1'b0});
					beats.push_back('{c, KIND_CHAR, 1'b0});
				end
			end else begin
				held_mark = HOLD_NONE;
				if (c == CH_SLASH)
					held_mark = HOLD_SLASH;
				else
					beats.push_back('{c, KIND_CHAR, 1'b0});
			end
		end
		for (int i = 0; i < beats.size(); i++) begin
			b = beats[i];
			b.last_of_run = (i == beats.size() - 1);
			stripped_beats.push_back(b);
		end
	endtask

	task automatic push_item(input logic [7:0] ch, input logic eos);
		src_item_t it;
		it.ch          = ch;
		it.eos         = eos;
		it.drain_first = drain_next;
		it.gap_after   = 0;
		drain_next     = 1'b0;
		if (tx_idle_on && $urandom_range(0, 7) == 0)
			it.gap_after = $urandom_range(1, 12);
		source_bytes.push_back(it);
		items_queued++;
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0:       return CH_SLASH;
			1:       return CH_STAR;
			2:       return CH_NL;
			3, 4, 5: return 8'($urandom_range(8'h61, 8'h7a));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// comment text: mostly letters, with newlines and single marks
	function automatic logic [7:0] pick_body();
		case ($urandom_range(0, 9))
			0:       return CH_NL;
			1:       return CH_STAR;
			2:       return CH_SLASH;
			3:       return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h61, 8'h7a));
		endcase
	endfunction

	task automatic push_block_comment();
		int levels;
		levels = $urandom_range(1, 3);
		for (int l = 0; l < levels; l++) begin
			push_item(CH_SLASH, 1'b0);
			push_item(CH_STAR, 1'b0);
			repeat ($urandom_range(0, 4)) push_item(pick_body(), 1'b0);
		end
		// leave some comments open to exercise the unterminated status
		if ($urandom_range(0, 9) != 0) begin
			for (int l = 0; l < levels; l++) begin
				push_item(CH_STAR, 1'b0);
				push_item(CH_SLASH, 1'b0);
				repeat ($urandom_range(0, 2)) push_item(pick_body(), 1'b0);
			end
		end
	endtask

	task automatic push_source();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 8)) push_item(pick_char(), 1'b0);
				3, 4: begin
					push_item(CH_SLASH, 1'b0);
					push_item(CH_SLASH, 1'b0);
					repeat ($urandom_range(0, 5)) push_item(8'($urandom_range(0, 255)), 1'b0);
					if ($urandom_range(0, 3) != 0)
						push_item(CH_NL, 1'b0);
				end
				5, 6, 7: push_block_comment();
				8: repeat ($urandom_range(1, 6)) push_item(pick_char(), 1'b0);
				default: begin
					push_item(CH_SLASH, 1'b0);
					push_item(pick_char(), 1'b0);
				end
			endcase
		end
		push_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic push_overflow_source();
		drain_next = 1'b1;
		push_item(CH_SLASH, 1'b0);
		push_item(CH_STAR, 1'b0);
		repeat (1 << DEPTH_W) begin
			push_item(CH_SLASH, 1'b0);
			push_item(CH_STAR, 1'b0);
		end
		repeat (3) begin
			push_item(CH_STAR, 1'b0);
			push_item(CH_SLASH, 1'b0);
		end
		push_item(CH_NL, 1'b0);
		push_item(8'h00, 1'b1);
	endtask

	// Source driver: present queued bytes, hold while stalled, idle for the gaps set on some beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid     <= 1'b0;
			char_byte     <= 8'h00;
			end_of_source <= 1'b0;
			gap_left      = 0;
		end else begin
			if (src_valid && !src_stall)
				strip_char(char_byte, end_of_source);
			if (src_valid && src_stall) begin
				// hold the beat
			end else if (gap_left > 0) begin
				gap_left--;
				src_valid <= 1'b0;
			end else if (source_bytes.size() > 0 &&
			             !(source_bytes[0].drain_first && stripped_beats.size() > 0)) begin
				next_item = source_bytes.pop_front();
				src_valid     <= 1'b1;
				char_byte     <= next_item.ch;
				end_of_source <= next_item.eos;
				gap_left      = next_item.gap_after;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Result monitor: check each accepted beat against the oldest prediction, and drive random stalls.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				got.out_char    = out_char;
				got.kind        = kind_t'(kind);
				got.last_of_run = last_of_run;
				if (stripped_beats.size() == 0) begin
					note_error($sformatf("unexpected beat char=%02h kind=%0d last=%0b",
					                     got.out_char, got.kind, got.last_of_run));
				end else begin
					want = stripped_beats.pop_front();
					if (got.out_char !== want.out_char || got.kind !== want.kind ||
					    got.last_of_run !== want.last_of_run)
						note_error($sformatf(
							"expected char=%02h kind=%0d last=%0b got char=%02h kind=%0d last=%0b",
							want.out_char, want.kind, want.last_of_run,
							got.out_char, got.kind, got.last_of_run));
				end
			end
			rx_phase++;
			if (rx_phase % 200 == 0)
				rx_idle_on = ($urandom_range(0, 2) != 0);
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (rx_idle_on && source_bytes.size() >= TAIL_ITEMS &&
			             $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 11);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		bit overflow_done;
		overflow_done = 1'b0;

		// directed: extremes, split slash, line and nested block comments, ok and open end states
		push_item(8'h61, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(8'h78, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(8'h7a, 1'b0);
		push_item(CH_NL, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_STAR, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_STAR, 1'b0);
		push_item(CH_NL, 1'b0);
		push_item(CH_STAR, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_STAR, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_STAR, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_SLASH, 1'b0);
		push_item(CH_SLASH, 1'b1);

		while (items_queued < TOTAL_ITEMS) begin
			if (items_queued > TOTAL_ITEMS - TAIL_ITEMS)
				tx_idle_on = 1'b0;
			else
				tx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 19) == 0)
				drain_next = 1'b1;
			if (!overflow_done && items_queued > 600) begin
				push_overflow_source();
				overflow_done = 1'b1;
			end else begin
				push_source();
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (source_bytes.size() > 0 || src_valid || stripped_beats.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/nsc_pkg.sv
rtl/nsc_scan.sv
rtl/nsc_res_fifo.sv
rtl/nested_comment_stripper_unit.sv
sim/nested_comment_stripper_unit_tb.sv
